/* design/german_word_tokenizer_assert.svh */
// ----------------------------------------------------------------------------
// German word tokenizer assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GERMAN_WORD_TOKENIZER_ASSERT_SVH
`define GERMAN_WORD_TOKENIZER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define GWT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tokenizer check failed (same cycle)");

// next-cycle implication, disabled while reset is low
`define GWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tokenizer check failed (next cycle)");

`endif

/* design/gwt_pkg.sv */
// ----------------------------------------------------------------------------
// gwt_pkg
// Types and constants shared by the German word tokenizer files.
// ----------------------------------------------------------------------------
package gwt_pkg;

    typedef enum logic [1:0] {
        KIND_WORD_BYTE  = 2'd0,
        KIND_WORD_END   = 2'd1,
        KIND_SPECIAL    = 2'd2,
        KIND_OVERLENGTH = 2'd3
    } t_kind;

    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] LEAD_BYTE      = 8'hC3;
    localparam logic [7:0] MAX_WORD_RESET = 8'd64;
    localparam logic [7:0] LEN_SATURATED  = 8'hFF;

    localparam logic [7:0] CHAR_LOW_A = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_LOW_Z = 8'h7A;  // 'z'
    localparam logic [7:0] CHAR_UP_A  = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;  // 'Z'

    // second bytes of the UTF-8 pairs after the lead byte
    localparam logic [7:0] TAIL_AE_UP = 8'h84;
    localparam logic [7:0] TAIL_OE_UP = 8'h96;
    localparam logic [7:0] TAIL_UE_UP = 8'h9C;
    localparam logic [7:0] TAIL_AE_LO = 8'hA4;
    localparam logic [7:0] TAIL_OE_LO = 8'hB6;
    localparam logic [7:0] TAIL_UE_LO = 8'hBC;
    localparam logic [7:0] TAIL_SZ    = 8'h9F;

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= CHAR_LOW_A) && (b <= CHAR_LOW_Z)) ||
               ((b >= CHAR_UP_A) && (b <= CHAR_UP_Z));
    endfunction

    function automatic logic is_pair_tail(input logic [7:0] b);
        return (b == TAIL_AE_UP) || (b == TAIL_OE_UP) || (b == TAIL_UE_UP) ||
               (b == TAIL_AE_LO) || (b == TAIL_OE_LO) || (b == TAIL_UE_LO) ||
               (b == TAIL_SZ);
    endfunction

endpackage

/* design/gwt_ifs.sv */
// ----------------------------------------------------------------------------
// German word tokenizer channels
// Valid/ready interfaces for the byte input, the token output and the
// configuration write channel.
// ----------------------------------------------------------------------------
interface gwt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_line_end;

    modport source (output valid, output data_byte, output has_byte,
                    output is_line_end, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input is_line_end, output ready);
endinterface

interface gwt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] token_byte;
    logic [1:0] token_kind;
    logic       last_of_run;

    modport source (output valid, output token_byte, output token_kind,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_byte, input token_kind,
                    input last_of_run, output ready);
endinterface

interface gwt_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] max_word_bytes;

    modport source (output valid, output max_word_bytes, input ready);
    modport sink   (input valid, input max_word_bytes, output ready);
endinterface

/* design/german_word_tokenizer.sv */
// ----------------------------------------------------------------------------
// german_word_tokenizer
// Splits a stream of line bytes into German words and special characters.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one item per line byte (data_byte, has_byte, is_line_end).
//   o_out  : token items (token_byte, token_kind, last_of_run); the tokens of
//            one input item come out in order, last_of_run on the final one.
//   i_cfg  : writes max_word_bytes; always ready, write only while idle.
// Output: the first token of an item is offered in the cycle after the item
//   is accepted. An item yields zero to four tokens, held in a four-entry
//   result buffer and sent one per cycle while o_out.ready is high.
// Throughput: one item per cycle while each item yields at most one token
//   and o_out.ready stays high; the single output port sets the rate
//   otherwise. A new item is taken in the cycle the last buffered token leaves.
// Reset: synchronous, active low; clears the word and lead-byte state, the
//   buffer, and sets max_word_bytes to 64.
// Stall: while o_out.ready is low the offered token holds, and input is
//   held off once the buffer has tokens that cannot drain this cycle.
// ----------------------------------------------------------------------------
module german_word_tokenizer (
    input  logic     i_clk,
    input  logic     i_rst_n,
    gwt_in_if.sink   i_in,
    gwt_out_if.source o_out,
    gwt_cfg_if.sink  i_cfg
);
    import gwt_pkg::*;

    `include "german_word_tokenizer_assert.svh"

    logic [7:0]           r_max_word;
    logic                 r_in_word;
    logic [7:0]           r_word_len;
    logic                 r_lead_pending;
    logic [7:0]           r_q_byte [MAX_RESULTS];
    t_kind                r_q_kind [MAX_RESULTS];
    logic [RES_CNT_W-1:0] r_rem;
    logic [RES_IDX_W-1:0] r_head;

    logic [7:0]           n_byte [MAX_RESULTS];
    t_kind                n_kind [MAX_RESULTS];
    logic [RES_CNT_W-1:0] n_cnt;
    logic                 n_in_word;
    logic [7:0]           n_word_len;
    logic                 n_lead_pending;

    logic in_fire;
    logic out_fire;
    logic cfg_fire;

    assign out_fire = o_out.valid && o_out.ready;
    assign in_fire  = i_in.valid && i_in.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_rem == '0) ||
                         ((r_rem == RES_CNT_W'(1)) && o_out.ready);

    assign o_out.valid       = (r_rem != '0);
    assign o_out.token_byte  = r_q_byte[r_head];
    assign o_out.token_kind  = r_q_kind[r_head];
    assign o_out.last_of_run = (r_rem == RES_CNT_W'(1));

    // Classify the item and build its token list.
    always_comb begin
        logic [7:0] b;
        logic       plain;
        logic       grow;
        logic [1:0] added;
        logic [8:0] sum;

        b              = i_in.data_byte;
        plain          = 1'b0;
        grow           = 1'b0;
        added          = 2'd0;
        sum            = '0;
        n_cnt          = '0;
        n_in_word      = r_in_word;
        n_word_len     = r_word_len;
        n_lead_pending = r_lead_pending;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            n_byte[k] = '0;
            n_kind[k] = KIND_WORD_BYTE;
        end

        if (i_in.has_byte) begin
            if (r_lead_pending) begin
                n_lead_pending = 1'b0;
                if (is_pair_tail(b)) begin
                    n_byte[n_cnt[RES_IDX_W-1:0]] = LEAD_BYTE;
                    n_kind[n_cnt[RES_IDX_W-1:0]] = KIND_WORD_BYTE;
                    n_cnt = n_cnt + RES_CNT_W'(1);
                    n_byte[n_cnt[RES_IDX_W-1:0]] = b;
                    n_kind[n_cnt[RES_IDX_W-1:0]] = KIND_WORD_BYTE;
                    n_cnt = n_cnt + RES_CNT_W'(1);
                    grow  = 1'b1;
                    added = 2'd2;
                end else begin
                    // unmatched lead: close word, pass lead on, then the byte
                    if (n_in_word) begin
                        n_kind[n_cnt[RES_IDX_W-1:0]] = KIND_WORD_END;
                        n_cnt = n_cnt + RES_CNT_W'(1);
                    end
                    n_byte[n_cnt[RES_IDX_W-1:0]] = LEAD_BYTE;
                    n_kind[n_cnt[RES_IDX_W-1:0]] = KIND_SPECIAL;
                    n_cnt      = n_cnt + RES_CNT_W'(1);
                    n_in_word  = 1'b0;
                    n_word_len = '0;
                    plain      = 1'b1;
                end
            end else begin
                plain = 1'b1;
            end

            if (plain) begin
                if (is_letter(b)) begin
                    n_byte[n_cnt[RES_IDX_W-1:0]] = b;
                    n_kind[n_cnt[RES_IDX_W-1:0]] = KIND_WORD_BYTE;
                    n_cnt = n_cnt + RES_CNT_W'(1);
                    grow  = 1'b1;
                    added = 2'd1;
                end else if (b == LEAD_BYTE) begin
                    n_lead_pending = 1'b1;
                end else begin
                    if (n_in_word) begin
                        n_kind[n_cnt[RES_IDX_W-1:0]] = KIND_WORD_END;
                        n_cnt = n_cnt + RES_CNT_W'(1);
                    end
                    n_byte[n_cnt[RES_IDX_W-1:0]] = b;
                    n_kind[n_cnt[RES_IDX_W-1:0]] = KIND_SPECIAL;
                    n_cnt      = n_cnt + RES_CNT_W'(1);
                    n_in_word  = 1'b0;
                    n_word_len = '0;
                end
            end

            if (grow) begin
                sum        = {1'b0, n_word_len} + {7'd0, added};
                n_word_len = sum[8] ? LEN_SATURATED : sum[7:0];
                n_in_word  = 1'b1;
                if (n_word_len >= r_max_word) begin
                    n_kind[n_cnt[RES_IDX_W-1:0]] = KIND_OVERLENGTH;
                    n_cnt      = n_cnt + RES_CNT_W'(1);
                    n_in_word  = 1'b0;
                    n_word_len = '0;
                end
            end
        end

        if (i_in.is_line_end) begin
            if (n_in_word) begin
                n_kind[n_cnt[RES_IDX_W-1:0]] = KIND_WORD_END;
                n_cnt = n_cnt + RES_CNT_W'(1);
            end
            if (n_lead_pending) begin
                n_byte[n_cnt[RES_IDX_W-1:0]] = LEAD_BYTE;
                n_kind[n_cnt[RES_IDX_W-1:0]] = KIND_SPECIAL;
                n_cnt = n_cnt + RES_CNT_W'(1);
            end
            n_in_word      = 1'b0;
            n_word_len     = '0;
            n_lead_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_word     <= MAX_WORD_RESET;
            r_in_word      <= 1'b0;
            r_word_len     <= '0;
            r_lead_pending <= 1'b0;
            r_rem          <= '0;
            r_head         <= '0;
        end else begin
            if (cfg_fire) begin
                r_max_word <= i_cfg.max_word_bytes;
            end
            if (in_fire) begin
                r_in_word      <= n_in_word;
                r_word_len     <= n_word_len;
                r_lead_pending <= n_lead_pending;
                r_rem          <= n_cnt;
                r_head         <= '0;
            end else if (out_fire) begin
                // advance to the next buffered token
                r_rem  <= r_rem - RES_CNT_W'(1);
                r_head <= r_head + RES_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                r_q_byte[k] <= n_byte[k];
                r_q_kind[k] <= n_kind[k];
            end
        end
    end

    `GWT_ASSERT_IMPL(a_len_zero_when_closed, i_clk, i_rst_n, !r_in_word, r_word_len == '0)
    `GWT_ASSERT_NEXT(a_line_end_clears, i_clk, i_rst_n, in_fire && i_in.is_line_end, !r_in_word && !r_lead_pending && (r_word_len == '0))
    `GWT_ASSERT_NEXT(a_stall_holds_head, i_clk, i_rst_n, o_out.valid && !o_out.ready && !in_fire, $stable(r_head) && $stable(r_rem))

endmodule

/* tb/german_word_tokenizer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// german_word_tokenizer_tb
// Drives line bytes into the tokenizer and checks every token against an entry
// of a short table or a prediction from a local copy of the word, length and
// lead-byte state. The table covers character class edges, umlaut pairs,
// stray lead bytes, line ends, word cuts and length saturation. Random text
// phases follow, each under its own word limit. Both channels idle at random.
// ----------------------------------------------------------------------------
module german_word_tokenizer_tb;
    import gwt_pkg::*;

    localparam int          PREDICT     = -1;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          PHASES      = 5;
    localparam int          PHASE_ITEMS = 24;
    localparam logic [7:0]  PAIR_TAILS [7] = '{TAIL_AE_UP, TAIL_OE_UP, TAIL_UE_UP,
                                               TAIL_AE_LO, TAIL_OE_LO, TAIL_UE_LO,
                                               TAIL_SZ};

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       eol;
    } t_byte_item;

    typedef struct packed {
        logic [7:0] tbyte;
        t_kind      kind;
        logic       last;
    } t_tok;

    typedef struct {
        logic       set_lim;
        logic [7:0] lim;
        t_byte_item item;
        int         reps;
        int         n_typed;
        t_tok       typed [2];
    } t_dir_row;

    logic clk = 1'b0;
    logic rst_n;

    gwt_in_if  byte_ch ();
    gwt_out_if tok_ch ();
    gwt_cfg_if cfg_ch ();

    german_word_tokenizer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (tok_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // tokenizer state as the block should hold it
    logic [7:0] lim_q     = MAX_WORD_RESET;
    logic       word_open = 1'b0;
    logic [7:0] word_len  = '0;
    logic       lead_held = 1'b0;

    t_tok       step_toks [$];
    t_tok       token_q [$];
    t_dir_row   dir_rows [$];
    t_byte_item text_q [$];

    int          burst_left = 0;
    int          mismatches = 0;
    int unsigned cycle_cnt  = 0;

    function automatic t_tok mk_tok(logic [7:0] b, t_kind k, logic last);
        t_tok t;
        t.tbyte = b;
        t.kind  = k;
        t.last  = last;
        return t;
    endfunction

    function automatic t_byte_item plain(logic [7:0] b);
        t_byte_item it;
        it.data = b;
        it.has  = 1'b1;
        it.eol  = 1'b0;
        return it;
    endfunction

    function automatic void put_tok(logic [7:0] b, t_kind k);
        step_toks.push_back(mk_tok(b, k, 1'b0));
    endfunction

    function automatic void end_word();
        if (word_open) begin
            put_tok(8'h00, KIND_WORD_END);
        end
        word_open = 1'b0;
        word_len  = '0;
    endfunction

    function automatic void extend_word(int unsigned added);
        int unsigned len;
        len = word_len + added;
        if (len > 255) begin
            len = 255;
        end
        word_len  = len[7:0];
        word_open = 1'b1;
        if (word_len >= lim_q) begin
            put_tok(8'h00, KIND_OVERLENGTH);
            word_open = 1'b0;
            word_len  = '0;
        end
    endfunction

    function automatic void take_byte(logic [7:0] b);
        if (b inside {[CHAR_UP_A:CHAR_UP_Z], [CHAR_LOW_A:CHAR_LOW_Z]}) begin
            put_tok(b, KIND_WORD_BYTE);
            extend_word(1);
        end else if (b == LEAD_BYTE) begin
            lead_held = 1'b1;
        end else begin
            end_word();
            put_tok(b, KIND_SPECIAL);
        end
    endfunction

    // stray lead byte: close the word and pass the lead byte on by itself
    function automatic void release_lead();
        end_word();
        put_tok(LEAD_BYTE, KIND_SPECIAL);
        lead_held = 1'b0;
    endfunction

    function automatic void tokenize_byte(t_byte_item it);
        int n;
        step_toks.delete();
        if (it.has) begin
            if (lead_held) begin
                if (it.data inside {TAIL_AE_UP, TAIL_OE_UP, TAIL_UE_UP, TAIL_AE_LO,
                                    TAIL_OE_LO, TAIL_UE_LO, TAIL_SZ}) begin
                    lead_held = 1'b0;
                    put_tok(LEAD_BYTE, KIND_WORD_BYTE);
                    put_tok(it.data, KIND_WORD_BYTE);
                    extend_word(2);
                end else begin
                    release_lead();
                    take_byte(it.data);
                end
            end else begin
                take_byte(it.data);
            end
        end
        if (it.eol) begin
            if (lead_held) begin
                release_lead();
            end else begin
                end_word();
            end
            word_open = 1'b0;
            word_len  = '0;
            lead_held = 1'b0;
        end
        n = step_toks.size();
        if (n > 0) begin
            step_toks[n - 1].last = 1'b1;
        end
    endfunction

    function automatic void add_row(logic set_lim, logic [7:0] lim, logic [7:0] data,
                                    logic has, logic eol, int reps, int n_typed,
                                    t_tok t0 = '0, t_tok t1 = '0);
        t_dir_row row;
        row.set_lim  = set_lim;
        row.lim      = lim;
        row.item     = plain(data);
        row.item.has = has;
        row.item.eol = eol;
        row.reps     = reps;
        row.n_typed  = n_typed;
        row.typed[0] = t0;
        row.typed[1] = t1;
        dir_rows.push_back(row);
    endfunction

    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic send_item(input t_byte_item it, input int n_typed,
                             input t_tok t0, input t_tok t1);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= it.data;
        byte_ch.has_byte    <= it.has;
        byte_ch.is_line_end <= it.eol;
        do @(posedge clk); while (!byte_ch.ready);
        tokenize_byte(it);
        if (n_typed == PREDICT) begin
            foreach (step_toks[k]) token_q.push_back(step_toks[k]);
        end else begin
            if (n_typed > 0) token_q.push_back(t0);
            if (n_typed > 1) token_q.push_back(t1);
        end
        burst_left--;
        @(negedge clk);
    endtask

    // Drop valid and wait until every token is out, then hold on a while, since
    // an item with no token may still be in flight.
    task automatic settle();
        byte_ch.valid <= 1'b0;
        burst_left = 0;
        while (token_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.max_word_bytes <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        lim_q = v;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic build_text(input int n);
        int         wl;
        t_byte_item it;
        text_q.delete();
        while (text_q.size() < n) begin
            if ($urandom_range(0, 99) < 80) begin
                wl = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                 : $urandom_range(1, 9);
                repeat (wl) begin
                    if ($urandom_range(0, 3) == 0) begin
                        text_q.push_back(plain(LEAD_BYTE));
                        text_q.push_back(plain(PAIR_TAILS[$urandom_range(0, 6)]));
                    end else if ($urandom_range(0, 1) == 0) begin
                        text_q.push_back(plain(8'($urandom_range(CHAR_UP_A, CHAR_UP_Z))));
                    end else begin
                        text_q.push_back(plain(8'($urandom_range(CHAR_LOW_A, CHAR_LOW_Z))));
                    end
                end
                case ($urandom_range(0, 4))
                    0: text_q.push_back(plain(8'h20));
                    // digits and punctuation
                    1: text_q.push_back(plain(8'($urandom_range(8'h21, 8'h40))));
                    2: begin
                        it = plain(8'($urandom));
                        it.has = 1'b0;
                        it.eol = 1'b1;
                        text_q.push_back(it);
                    end
                    3: begin
                        it = plain(8'h2E);
                        it.eol = 1'b1;
                        text_q.push_back(it);
                    end
                    default: ; // run straight into the next word
                endcase
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        it = plain(8'($urandom));
                        it.has = 1'($urandom_range(0, 1));
                        it.eol = ($urandom_range(0, 4) == 0);
                        text_q.push_back(it);
                    end
                    1: begin
                        text_q.push_back(plain(LEAD_BYTE));
                        text_q.push_back(plain(8'($urandom)));
                    end
                    2: begin
                        text_q.push_back(plain(LEAD_BYTE));
                        it = plain(8'($urandom));
                        it.has = 1'b0;
                        it.eol = 1'b1;
                        text_q.push_back(it);
                    end
                    default: begin
                        it = plain(8'($urandom));
                        it.has = 1'b0;
                        text_q.push_back(it);
                    end
                endcase
            end
        end
        // trim the last word back to the phase length
        while (text_q.size() > n) void'(text_q.pop_back());
    endtask

    // receiver: stall on a rotating 16-bit pattern, reshuffled now and then
    logic [15:0] stall_pat = 16'hFFFF;
    int          pat_left  = 0;

    always @(negedge clk) begin
        if (pat_left == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pat = 16'hFFFF;
                1: stall_pat = 16'($urandom) | 16'h0001;
                2: stall_pat = 16'($urandom | $urandom) | 16'h0001;
                default: stall_pat = 16'($urandom & $urandom) | 16'h0001;
            endcase
            pat_left = $urandom_range(20, 120);
        end
        pat_left--;
        tok_ch.ready <= stall_pat[pat_left % 16];
    end

    always @(posedge clk) begin : check_tokens
        t_tok want;
        if (rst_n && tok_ch.valid && tok_ch.ready) begin
            if (token_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("cycle %0d: unexpected token byte %02h kind %0d last %0b",
                             cycle_cnt, tok_ch.token_byte, tok_ch.token_kind,
                             tok_ch.last_of_run);
                end
            end else begin
                want = token_q.pop_front();
                if (tok_ch.token_byte !== want.tbyte || tok_ch.token_kind !== want.kind ||
                    tok_ch.last_of_run !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"cycle %0d: token mismatch, ",
                                  "expected %02h/%0d/%0b, got %02h/%0d/%0b"},
                                 cycle_cnt, want.tbyte, want.kind, want.last,
                                 tok_ch.token_byte, tok_ch.token_kind, tok_ch.last_of_run);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens outstanding",
                     cycle_cnt, token_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [7:0] lim;
        rst_n                 = 1'b0;
        byte_ch.valid         = 1'b0;
        byte_ch.data_byte     = '0;
        byte_ch.has_byte      = 1'b0;
        byte_ch.is_line_end   = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.max_word_bytes = '0;
        tok_ch.ready          = 1'b0;

        // reset limit, letter edges and specials
        add_row(0, 0, CHAR_UP_A, 1, 0, 1, 1, mk_tok(CHAR_UP_A, KIND_WORD_BYTE, 1));
        add_row(0, 0, CHAR_LOW_Z, 1, 1, 1, 2, mk_tok(CHAR_LOW_Z, KIND_WORD_BYTE, 0),
                mk_tok(8'h00, KIND_WORD_END, 1));
        add_row(0, 0, 8'h40, 1, 0, 1, 1, mk_tok(8'h40, KIND_SPECIAL, 1));
        add_row(0, 0, 8'h5B, 1, 0, 1, 1, mk_tok(8'h5B, KIND_SPECIAL, 1));
        add_row(0, 0, 8'h60, 1, 0, 1, 1, mk_tok(8'h60, KIND_SPECIAL, 1));
        add_row(0, 0, 8'h7B, 1, 0, 1, 1, mk_tok(8'h7B, KIND_SPECIAL, 1));
        add_row(0, 0, 8'h00, 1, 0, 1, 1, mk_tok(8'h00, KIND_SPECIAL, 1));
        add_row(0, 0, 8'hFF, 1, 0, 1, 1, mk_tok(8'hFF, KIND_SPECIAL, 1));
        // empty item and bare line end with nothing open
        add_row(0, 0, 8'hFF, 0, 0, 1, 0);
        add_row(0, 0, 8'h00, 0, 1, 1, 0);
        // umlaut pair inside a word, then a stray lead byte
        add_row(0, 0, CHAR_UP_Z, 1, 0, 1, PREDICT);
        add_row(0, 0, LEAD_BYTE, 1, 0, 1, PREDICT);
        add_row(0, 0, TAIL_AE_LO, 1, 0, 1, PREDICT);
        add_row(0, 0, LEAD_BYTE, 1, 0, 1, PREDICT);
        add_row(0, 0, 8'h78, 1, 0, 1, PREDICT);
        // two lead bytes, then a line end flushing the held one
        add_row(0, 0, LEAD_BYTE, 1, 0, 1, PREDICT);
        add_row(0, 0, LEAD_BYTE, 1, 0, 1, PREDICT);
        add_row(0, 0, 8'h00, 0, 1, 1, PREDICT);
        // four tokens from one item
        add_row(0, 0, 8'h62, 1, 0, 1, PREDICT);
        add_row(0, 0, LEAD_BYTE, 1, 0, 1, PREDICT);
        add_row(0, 0, 8'h63, 1, 1, 1, PREDICT);
        // smallest limit, pair pushing past it
        add_row(1, 2, 8'h61, 1, 0, 1, 1, mk_tok(8'h61, KIND_WORD_BYTE, 1));
        add_row(0, 0, 8'h62, 1, 0, 1, 2, mk_tok(8'h62, KIND_WORD_BYTE, 0),
                mk_tok(8'h00, KIND_OVERLENGTH, 1));
        add_row(0, 0, 8'h63, 1, 0, 1, PREDICT);
        add_row(0, 0, LEAD_BYTE, 1, 0, 1, PREDICT);
        add_row(0, 0, TAIL_SZ, 1, 0, 1, PREDICT);
        // largest limit: a pair at 254 saturates the length
        add_row(1, 255, 8'h71, 1, 0, 254, PREDICT);
        add_row(0, 0, LEAD_BYTE, 1, 0, 1, PREDICT);
        add_row(0, 0, TAIL_OE_LO, 1, 0, 1, PREDICT);
        add_row(0, 0, 8'h65, 1, 1, 1, PREDICT);

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].set_lim) begin
                settle();
                write_limit(dir_rows[r].lim);
            end
            repeat (dir_rows[r].reps) begin
                send_item(dir_rows[r].item, dir_rows[r].n_typed,
                          dir_rows[r].typed[0], dir_rows[r].typed[1]);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: lim = 8'd2;
                1: lim = 8'd255;
                2: lim = 8'($urandom_range(3, 12));
                3: lim = 8'($urandom_range(2, 255));
                default: lim = MAX_WORD_RESET;
            endcase
            settle();
            write_limit(lim);
            build_text(PHASE_ITEMS);
            foreach (text_q[i]) send_item(text_q[i], PREDICT, '0, '0);
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
